>>> hw/rtl/bdr_pkg.sv
package bdr_pkg;

  localparam logic [7:0] CodeReleased       = 8'hFF;
  localparam logic [7:0] LongMask           = 8'h7F;
  localparam logic [7:0] RepeatFloor        = 8'd2;
  localparam logic [7:0] DebounceTicksReset = 8'd4;
  localparam logic [7:0] LongPressReset     = 8'd20;

  typedef enum logic [0:0] {
    CfgDebounceTicks  = 1'b0,
    CfgLongPressUnits = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] prev_code;
    logic [7:0] deb_cnt;
    logic [7:0] hold_cnt;
    logic       long_rep;
    logic [7:0] rep_lim;
    logic       fast;
  } state_t;

  typedef struct packed {
    logic [7:0] debounce_ticks;
    logic [7:0] long_press_units;
  } cfg_t;

  typedef struct packed {
    logic       event_valid;
    logic [7:0] event_code;
  } result_t;

endpackage

>>> hw/rtl/bdr_step.sv
module bdr_step (
  input  bdr_pkg::state_t  state_i,
  input  bdr_pkg::cfg_t    cfg_i,
  input  logic [7:0]       raw_code_i,
  input  logic             set_fast_i,
  output bdr_pkg::state_t  state_o,
  output bdr_pkg::result_t result_o
);

  logic       fast;
  logic [7:0] deb_inc;
  logic [7:0] hold_inc;
  logic [7:0] lim_half;
  logic       valid;
  logic [7:0] ev;

  always_comb begin
    fast     = state_i.fast | set_fast_i;
    deb_inc  = state_i.deb_cnt + 8'd1;
    hold_inc = state_i.hold_cnt + 8'd1;
    lim_half = {1'b0, state_i.rep_lim[7:1]};
    valid    = 1'b0;
    ev       = state_i.prev_code;
    state_o  = state_i;
    state_o.prev_code = raw_code_i;

    if (raw_code_i == bdr_pkg::CodeReleased || raw_code_i != state_i.prev_code) begin
      // release or change: short press unless a long one was reported; long event if the hold count reached the limit
      if ((state_i.deb_cnt >= cfg_i.debounce_ticks || state_i.hold_cnt != 8'd0)
          && !state_i.long_rep) begin
        valid = 1'b1;
      end
      if (state_i.hold_cnt >= state_i.rep_lim) begin
        valid = 1'b1;
        ev    = state_i.prev_code & bdr_pkg::LongMask;
      end
      state_o.fast     = 1'b0;
      state_o.long_rep = 1'b0;
      state_o.rep_lim  = cfg_i.long_press_units;
      state_o.deb_cnt  = 8'd0;
      state_o.hold_cnt = 8'd0;
    end else begin
      state_o.fast = fast;
      if (deb_inc >= cfg_i.debounce_ticks) begin
        state_o.deb_cnt = 8'd0;
        if (hold_inc >= state_i.rep_lim) begin
          valid            = 1'b1;
          ev               = state_i.prev_code & bdr_pkg::LongMask;
          state_o.hold_cnt = 8'd0;
          state_o.long_rep = 1'b1;
          if (fast) begin
            state_o.rep_lim = (lim_half <= bdr_pkg::RepeatFloor) ? bdr_pkg::RepeatFloor
                                                                  : lim_half;
          end
        end else begin
          state_o.hold_cnt = hold_inc;
        end
      end else begin
        state_o.deb_cnt = deb_inc;
      end
    end

    result_o.event_valid = valid;
    result_o.event_code  = valid ? ev : 8'd0;
  end

endmodule

>>> hw/rtl/button_debounce_repeat.sv
// Button debounce with auto repeat.
// Each input transfer is captured in the input register; its result is then registered
// in the result register and offered on the output stream.
// Throughput: one item per cycle while the output is not stalled; one result per item.
// Reset: state all released, counters zero, repeat limit 20, registers 4 / 20,
// no item or result pending.
module button_debounce_repeat (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] raw_code
  input  logic       s_axis_tuser,  // [0] set_fast
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [7:0] event_code
  output logic       m_axis_tuser   // [0] event_valid
);

  bdr_pkg::cfg_t    cfg_q;
  bdr_pkg::state_t  state_q, state_d;
  bdr_pkg::result_t res_d, res_q;
  logic             in_valid_q;
  logic [7:0]       in_code_q;
  logic             in_fast_q;
  logic             out_valid_q;
  logic             advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks   <= bdr_pkg::DebounceTicksReset;
      cfg_q.long_press_units <= bdr_pkg::LongPressReset;
    end else if (cfg_we_i) begin
      unique case (bdr_pkg::cfg_idx_e'(cfg_idx_i))
        bdr_pkg::CfgDebounceTicks:  cfg_q.debounce_ticks   <= cfg_data_i;
        bdr_pkg::CfgLongPressUnits: cfg_q.long_press_units <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_code_q <= s_axis_tdata;
      in_fast_q <= s_axis_tuser;
    end
  end

  bdr_step u_step (
    .state_i    (state_q),
    .cfg_i      (cfg_q),
    .raw_code_i (in_code_q),
    .set_fast_i (in_fast_q),
    .state_o    (state_d),
    .result_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.prev_code <= bdr_pkg::CodeReleased;
      state_q.deb_cnt   <= 8'd0;
      state_q.hold_cnt  <= 8'd0;
      state_q.long_rep  <= 1'b0;
      state_q.rep_lim   <= bdr_pkg::LongPressReset;
      state_q.fast      <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = res_q.event_code;
  assign m_axis_tuser  = res_q.event_valid;

  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without a transfer");

  a_no_code_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.event_valid |-> res_q.event_code == 8'd0)
    else $error("event code set without event");

  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_code_q == bdr_pkg::CodeReleased |=>
      state_q.hold_cnt == 8'd0 && state_q.deb_cnt == 8'd0 && !state_q.fast
      && !state_q.long_rep)
    else $error("release did not clear state");

  a_long_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && state_q.long_rep && !state_d.long_rep |-> state_d.rep_lim
      == cfg_q.long_press_units)
    else $error("repeat limit not reloaded");

endmodule
